// ===== sv/phd_pkg.sv =====
`timescale 1ns / 1ps

package phd_pkg;

    localparam int HDR_LEN      = 24;
    localparam int HDR_W        = HDR_LEN * 8;
    localparam int HDR_CNT_W    = $clog2(HDR_LEN);

    // Fixed header magic, first four bytes on the wire
    localparam logic [31:0] HDR_MAGIC = 32'h4A44_4154;

    localparam logic [7:0]  EXPECTED_VERSION_RST   = 8'd1;
    localparam logic [31:0] MAX_PAYLOAD_LENGTH_RST = 32'd65536;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_EXPECTED_VERSION   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_PAYLOAD_LENGTH = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_REJECT  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_HEADER,
        ST_PAYLOAD,
        ST_STOPPED
    } t_state;

    typedef struct packed {
        t_kind        kind;
        logic [7:0]   packet_type;
        logic [15:0]  header_flags;
        logic [31:0]  announced_length;
        logic [63:0]  timestamp;
        logic [31:0]  sequence_number;
        logic [7:0]   payload_byte;
        logic         packet_end;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_res_push;

endpackage

// ===== sv/phd_ifs.sv =====
`timescale 1ns / 1ps

interface phd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface phd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  packet_type;
    logic [15:0] header_flags;
    logic [31:0] announced_length;
    logic [63:0] timestamp;
    logic [31:0] sequence_number;
    logic [7:0]  payload_byte;
    logic        packet_end;

    modport source (
        output valid, output kind, output packet_type, output header_flags,
        output announced_length, output timestamp, output sequence_number,
        output payload_byte, output packet_end, input ready
    );
    modport sink (
        input valid, input kind, input packet_type, input header_flags,
        input announced_length, input timestamp, input sequence_number,
        input payload_byte, input packet_end, output ready
    );
endinterface

interface phd_cfg_if;
    import phd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== sv/phd_parser.sv =====
`timescale 1ns / 1ps

module phd_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [7:0]         i_byte,
    input  logic [7:0]         i_expected_version,
    input  logic [31:0]        i_max_payload_length,
    output phd_pkg::t_res_push o_push
);
    import phd_pkg::*;

    localparam int KEEP_W = HDR_W - 8;

    t_state               r_state, n_state;
    logic [HDR_CNT_W-1:0] r_hdr_cnt, n_hdr_cnt;
    logic [31:0]          r_remain, n_remain;
    logic [KEEP_W-1:0]    r_hdr;

    logic [HDR_W-1:0] full_hdr;
    logic             last_hdr;
    logic             good;
    logic [31:0]      len;

    // Byte 0 of the header sits in the top bits
    assign full_hdr = {r_hdr, i_byte};
    assign last_hdr = (r_hdr_cnt == HDR_CNT_W'(HDR_LEN - 1));
    assign len      = full_hdr[HDR_W-1-64 -: 32];
    assign good     = (full_hdr[HDR_W-1 -: 32] == HDR_MAGIC)
                    && (full_hdr[HDR_W-1-32 -: 8] == i_expected_version)
                    && (len <= i_max_payload_length);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_HEADER: begin
                if (i_take && last_hdr) begin
                    if (!good)
                        n_state = ST_STOPPED;
                    else if (len != 32'd0)
                        n_state = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                if (i_take && r_remain == 32'd1)
                    n_state = ST_HEADER;
            end
            ST_STOPPED: n_state = ST_STOPPED;
            default:    n_state = ST_STOPPED;
        endcase
    end

    always_comb begin
        o_push    = '0;
        n_hdr_cnt = r_hdr_cnt;
        n_remain  = r_remain;
        unique case (r_state)
            ST_HEADER: begin
                if (i_take) begin
                    n_hdr_cnt = r_hdr_cnt + HDR_CNT_W'(1);
                    if (last_hdr) begin
                        n_hdr_cnt    = '0;
                        o_push.valid = 1'b1;
                        if (!good) begin
                            o_push.data.kind = KIND_REJECT;
                        end else begin
                            o_push.data.kind             = KIND_HEADER;
                            o_push.data.packet_type      = full_hdr[HDR_W-1-40 -: 8];
                            o_push.data.header_flags     = full_hdr[HDR_W-1-48 -: 16];
                            o_push.data.announced_length = len;
                            o_push.data.timestamp        = full_hdr[HDR_W-1-96 -: 64];
                            o_push.data.sequence_number  = full_hdr[HDR_W-1-160 -: 32];
                            o_push.data.packet_end       = (len == 32'd0);
                            n_remain                     = len;
                        end
                    end
                end
            end
            ST_PAYLOAD: begin
                if (i_take) begin
                    o_push.valid             = 1'b1;
                    o_push.data.kind         = KIND_PAYLOAD;
                    o_push.data.payload_byte = i_byte;
                    o_push.data.packet_end   = (r_remain == 32'd1);
                    n_remain                 = r_remain - 32'd1;
                end
            end
            ST_STOPPED: begin
                o_push = '0;
            end
            default: begin
                o_push = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_HEADER;
            r_hdr_cnt <= '0;
            r_remain  <= '0;
        end else begin
            r_state   <= n_state;
            r_hdr_cnt <= n_hdr_cnt;
            r_remain  <= n_remain;
        end
    end

    // header shift line, no reset
    always_ff @(posedge i_clk) begin
        if (i_take && r_state == ST_HEADER)
            r_hdr <= {r_hdr[KEEP_W-9:0], i_byte};
    end

endmodule

// ===== sv/phd_skid.sv =====
`timescale 1ns / 1ps

module phd_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  phd_pkg::t_res_push i_push,
    output logic               o_can_push,
    input  logic               i_ready,
    output logic               o_valid,
    output phd_pkg::t_result   o_data
);
    import phd_pkg::*;

    logic    r_main_valid, r_skid_valid;
    t_result r_main, r_skid;
    logic    drain;

    assign drain      = r_main_valid && i_ready;
    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_data     = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (drain)
                r_skid_valid <= 1'b0;
        end else if (!r_main_valid || drain) begin
            r_main_valid <= i_push.valid;
        end else if (i_push.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (drain)
                r_main <= r_skid;
        end else if (!r_main_valid || drain) begin
            if (i_push.valid)
                r_main <= i_push.data;
        end else if (i_push.valid) begin
            r_skid <= i_push.data;
        end
    end

endmodule

// ===== sv/packet_header_deframer_top.sv =====
`timescale 1ns / 1ps

// Stream deframer: one byte is taken per clock on i_in. Each packet opens
// with a 24-byte big-endian header (magic, version, type, flags, payload
// length, timestamp, sequence). The last header byte yields one result:
// kind 0 with the header fields if magic, version and length limit all
// pass, otherwise kind 2 and the parser stops, swallowing every later byte
// without result until reset. After a good header each payload byte gives
// one kind 1 result, the last one flagged by packet_end; an empty payload
// ends the packet at its header result. Earlier header bytes give no
// result. Rate: one byte per cycle while o_out keeps up; each result is
// registered in the output stage. A two-entry output stage (output register
// plus skid entry) decouples the sides, so i_in.ready only drops once both
// entries hold results that o_out has not yet taken. Configuration writes
// on i_cfg are always taken and should only be made while the block is
// idle; writes to unknown indexes are dropped.
module packet_header_deframer_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    phd_in_if.sink    i_in,
    phd_out_if.source o_out,
    phd_cfg_if.sink   i_cfg
);
    import phd_pkg::*;

    logic [7:0]  r_exp_ver;
    logic [31:0] r_max_len;
    logic        take;
    logic        can_push;
    t_res_push   push;
    t_result     out_data;
    logic        out_valid;

    // config registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ver <= EXPECTED_VERSION_RST;
            r_max_len <= MAX_PAYLOAD_LENGTH_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                CFG_IDX_EXPECTED_VERSION:   r_exp_ver <= i_cfg.wr_data[7:0];
                CFG_IDX_MAX_PAYLOAD_LENGTH: r_max_len <= i_cfg.wr_data[31:0];
                default: ;
            endcase
        end
    end

    // input transfer: ready whenever the skid entry is free
    assign i_in.ready = can_push;
    assign take       = i_in.valid && can_push;

    phd_parser u_parser (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_take              (take),
        .i_byte              (i_in.in_byte),
        .i_expected_version  (r_exp_ver),
        .i_max_payload_length(r_max_len),
        .o_push              (push)
    );

    phd_skid u_skid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_can_push(can_push),
        .i_ready   (o_out.ready),
        .o_valid   (out_valid),
        .o_data    (out_data)
    );

    assign o_out.valid            = out_valid;
    assign o_out.kind             = out_data.kind;
    assign o_out.packet_type      = out_data.packet_type;
    assign o_out.header_flags     = out_data.header_flags;
    assign o_out.announced_length = out_data.announced_length;
    assign o_out.timestamp        = out_data.timestamp;
    assign o_out.sequence_number  = out_data.sequence_number;
    assign o_out.payload_byte     = out_data.payload_byte;
    assign o_out.packet_end       = out_data.packet_end;

`ifndef SYNTHESIS
    // back-pressure only while a result is waiting at the output
    a_stall_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> out_valid)
        else $error("input stalled with empty output stage");

    // a result is only produced from an accepted byte
    a_push_needs_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> take)
        else $error("result produced without input transfer");

    // a reject never completes a packet
    a_reject_no_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && out_data.kind == KIND_REJECT) |-> !out_data.packet_end)
        else $error("reject result flagged as packet end");

    // a reject is not immediately followed by another result
    a_silent_after_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.valid && push.data.kind == KIND_REJECT) |=> !push.valid)
        else $error("result after reject");
`endif

endmodule
